// ===== src/c_subset_lexer_unit_macros.svh =====
// Assertion macros shared by the lexer checker.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef C_SUBSET_LEXER_UNIT_MACROS_SVH
`define C_SUBSET_LEXER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLX_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLX_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

// ===== src/clx_pkg.sv =====
// Shared types, token codes, byte classes and keyword tables of the lexer.
// No dependencies; imported by every lexer module.
`default_nettype none

package clx_pkg;

    // Token kind codes as they appear on the result channel.
    typedef enum logic [2:0] {
        KIND_PUNCT   = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_KEYWORD = 3'd2,
        KIND_NUMBER  = 3'd3,
        KIND_STRING  = 3'd4,
        KIND_EOF     = 3'd5,
        KIND_UNTERM  = 3'd6,
        KIND_INVALID = 3'd7
    } kind_t;

    // Scanner modes, one-hot.
    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_IDENT  = 5'b00010,
        MODE_NUMBER = 5'b00100,
        MODE_STRING = 5'b01000,
        MODE_HELD   = 5'b10000
    } lex_mode_t;

    // Characters with a special meaning to the scanner.
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;
    localparam int          NUM_KW  = 8;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || (b == 8'h5F);
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
               (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
    endfunction

    // Operators that may take a trailing '=' to form a two-byte operator.
    function automatic logic is_held_op(input logic [7:0] b);
        return (b == CH_LT) || (b == CH_GT) || (b == CH_EQ) || (b == CH_BANG);
    endfunction

    // Keyword text, left-justified in six bytes, zero padded.
    function automatic logic [47:0] kw_word(input logic [2:0] k);
        logic [47:0] w;
        case (k)
            3'd0:    w = {"if", 32'h0};
            3'd1:    w = {"else", 16'h0};
            3'd2:    w = "return";
            3'd3:    w = {"for", 24'h0};
            3'd4:    w = {"while", 8'h0};
            3'd5:    w = {"int", 24'h0};
            3'd6:    w = "sizeof";
            3'd7:    w = {"char", 16'h0};
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] n;
        case (k)
            3'd0:    n = 3'd2;
            3'd1:    n = 3'd4;
            3'd2:    n = 3'd6;
            3'd3:    n = 3'd3;
            3'd4:    n = 3'd5;
            3'd5:    n = 3'd3;
            3'd6:    n = 3'd6;
            3'd7:    n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Byte of keyword k at offset off; zero past the sixth byte.
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] off);
        logic [47:0] w;
        logic [2:0]  slot;
        w    = kw_word(k);
        slot = 3'd5 - off;
        if (off > 3'd5)
            return 8'h00;
        return w[{slot, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== src/clx_engine.sv =====
// Scanner state and the combinational byte step of the lexer.
// Depends on clx_pkg; produces up to three tokens per byte for clx_tokbuf.
`default_nettype none

module clx_engine
    import clx_pkg::*;
#(
    parameter int POSITION_BITS = 16,
    parameter int LENGTH_BITS   = 12,
    localparam int TOK_W        = 53 + POSITION_BITS + LENGTH_BITS
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic [7:0]       text_byte,
    input  wire logic             end_of_text,
    output logic      [TOK_W-1:0] pkt_tok [3],
    output logic      [1:0]       pkt_count
);

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [LENGTH_BITS-1:0]   len_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  p2;
        logic [7:0]  p1;
        logic [2:0]  kw;
        logic [30:0] value;
        len_t        len;
        pos_t        start;
    } tok_t;

    typedef struct packed {
        logic v;
        tok_t t;
    } res_t;

    localparam len_t LEN_MAX = {LENGTH_BITS{1'b1}};

    lex_mode_t   mode_reg,  mode_next;
    pos_t        pos_reg,   pos_next;
    pos_t        start_reg, start_next;
    len_t        len_reg,   len_next;
    logic [30:0] acc_reg,   acc_next;
    logic [7:0]  cand_reg,  cand_next;
    logic [7:0]  held_reg,  held_next;
    logic        halt_reg,  halt_next;

    res_t tok_a, tok_m, tok_d;

    function automatic tok_t make_tok(input kind_t k, input pos_t s, input len_t l,
                                      input logic [30:0] v, input logic [2:0] kw,
                                      input logic [7:0] p1, input logic [7:0] p2);
        tok_t t;
        t.kind  = k;
        t.start = s;
        t.len   = l;
        t.value = v;
        t.kw    = kw;
        t.p1    = p1;
        t.p2    = p2;
        return t;
    endfunction

    function automatic len_t bump(input len_t l);
        return (l < LEN_MAX) ? l + len_t'(1) : l;
    endfunction

    // Drop keywords whose byte at offset off differs from b.
    function automatic logic [7:0] prune(input logic [7:0] cand, input len_t off,
                                         input logic [7:0] b);
        logic [7:0] keep;
        for (int k = 0; k < NUM_KW; k++)
            keep[k] = cand[k] && (off < len_t'(kw_len(3'(k)))) &&
                      (kw_char(3'(k), off[2:0]) == b);
        return keep;
    endfunction

    // Token that closes the open run, if any.
    function automatic res_t flush_tok(input lex_mode_t md, input pos_t ts, input len_t ln,
                                       input logic [30:0] acc, input logic [7:0] cand,
                                       input logic [7:0] held);
        res_t       r;
        logic       hit;
        logic [2:0] kwi;
        r   = '0;
        hit = 1'b0;
        kwi = '0;
        case (md)
            MODE_IDENT:
            begin
                // Lowest-numbered surviving keyword of matching length wins.
                for (int k = NUM_KW - 1; k >= 0; k--)
                    if (cand[k] && (ln == len_t'(kw_len(3'(k)))))
                    begin
                        hit = 1'b1;
                        kwi = 3'(k);
                    end
                r.v = 1'b1;
                r.t = make_tok(hit ? KIND_KEYWORD : KIND_IDENT, ts, ln, '0, kwi, '0, '0);
            end
            MODE_NUMBER:
            begin
                r.v = 1'b1;
                r.t = make_tok(KIND_NUMBER, ts, ln, acc, '0, '0, '0);
            end
            MODE_STRING:
            begin
                r.v = 1'b1;
                r.t = make_tok(KIND_UNTERM, ts, ln, '0, '0, '0, '0);
            end
            MODE_HELD:
            begin
                r.v = 1'b1;
                r.t = make_tok(KIND_PUNCT, ts, len_t'(1), '0, '0, held, '0);
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    // Byte step: take the byte into the open run, start a new run, close the stream.
    always_comb
    begin
        logic        flush_begin;
        logic [34:0] wide;
        logic [7:0]  b;
        pos_t        pos_inc;
        res_t        tok_b;
        res_t        tok_c;

        b           = text_byte;
        pos_inc     = pos_reg + pos_t'(1);
        flush_begin = 1'b0;
        wide        = '0;
        tok_b       = '0;
        tok_c       = '0;
        tok_a       = '0;
        tok_d       = '0;

        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        cand_next  = cand_reg;
        held_next  = held_reg;
        halt_next  = halt_reg;

        if (b == 8'h00)
        begin
            if (!halt_reg)
                tok_a = flush_tok(mode_reg, start_reg, len_reg, acc_reg, cand_reg, held_reg);
            tok_d.v = 1'b1;
            tok_d.t = make_tok(KIND_EOF, pos_reg, '0, '0, '0, '0, '0);
        end
        else
        begin
            if (!halt_reg)
            begin
                case (mode_reg)
                    MODE_IDENT:
                    begin
                        if (is_alpha(b) || is_digit(b))
                        begin
                            cand_next = prune(cand_reg, len_reg, b);
                            len_next  = bump(len_reg);
                        end
                        else
                            flush_begin = 1'b1;
                    end
                    MODE_NUMBER:
                    begin
                        if (is_digit(b))
                        begin
                            wide = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) +
                                   35'(b - CH_ZERO);
                            acc_next = (wide > 35'(NUM_MAX)) ? NUM_MAX : wide[30:0];
                            len_next = bump(len_reg);
                        end
                        else
                            flush_begin = 1'b1;
                    end
                    MODE_STRING:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            len_next  = bump(len_reg);
                            tok_a.v   = 1'b1;
                            tok_a.t   = make_tok(KIND_STRING, start_reg, len_next,
                                                 '0, '0, '0, '0);
                            mode_next = MODE_IDLE;
                        end
                        else if (b == CH_NEWLINE)
                        begin
                            tok_a.v   = 1'b1;
                            tok_a.t   = make_tok(KIND_UNTERM, start_reg, len_reg,
                                                 '0, '0, '0, '0);
                            mode_next = MODE_IDLE;
                            halt_next = 1'b1;
                        end
                        else
                            len_next = bump(len_reg);
                    end
                    MODE_HELD:
                    begin
                        if (b == CH_EQ)
                        begin
                            tok_a.v   = 1'b1;
                            tok_a.t   = make_tok(KIND_PUNCT, start_reg, len_t'(2),
                                                 '0, '0, held_reg, CH_EQ);
                            mode_next = MODE_IDLE;
                        end
                        else
                            flush_begin = 1'b1;
                    end
                    default:
                    begin
                        flush_begin = 1'b1;
                    end
                endcase

                if (flush_begin)
                begin
                    tok_a     = flush_tok(mode_reg, start_reg, len_reg, acc_reg,
                                          cand_reg, held_reg);
                    mode_next = MODE_IDLE;
                    // Start a new run unless the byte is whitespace.
                    if (!is_space(b))
                    begin
                        start_next = pos_reg;
                        len_next   = len_t'(1);
                        if (b == CH_QUOTE)
                            mode_next = MODE_STRING;
                        else if (is_digit(b))
                        begin
                            mode_next = MODE_NUMBER;
                            acc_next  = 31'(b - CH_ZERO);
                        end
                        else if (is_alpha(b))
                        begin
                            mode_next = MODE_IDENT;
                            cand_next = prune(8'hFF, '0, b);
                        end
                        else if (is_held_op(b))
                        begin
                            mode_next = MODE_HELD;
                            held_next = b;
                        end
                        else if (is_punct(b))
                        begin
                            tok_b.v = 1'b1;
                            tok_b.t = make_tok(KIND_PUNCT, pos_reg, len_t'(1),
                                               '0, '0, b, '0);
                        end
                        else
                        begin
                            tok_b.v   = 1'b1;
                            tok_b.t   = make_tok(KIND_INVALID, pos_reg, len_t'(1),
                                                 '0, '0, '0, '0);
                            halt_next = 1'b1;
                        end
                    end
                end
            end

            pos_next = pos_inc;

            // End mark: close whatever run is still open, then EOF.
            if (end_of_text)
            begin
                if (!halt_next)
                    tok_c = flush_tok(mode_next, start_next, len_next, acc_next,
                                      cand_next, held_next);
                tok_d.v = 1'b1;
                tok_d.t = make_tok(KIND_EOF, pos_inc, '0, '0, '0, '0, '0);
            end
        end

        // A run that closes at the end mark never coexists with a begin token.
        tok_m = tok_b.v ? tok_b : tok_c;

        // Stream end puts every register back to its start value.
        if (tok_d.v)
        begin
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
            acc_next   = '0;
            cand_next  = 8'hFF;
            held_next  = '0;
            halt_next  = 1'b0;
        end
    end

    // Pack the valid tokens in order into the packet slots.
    always_comb
    begin
        pkt_tok[0] = tok_a.v ? tok_a.t : (tok_m.v ? tok_m.t : tok_d.t);
        pkt_tok[1] = (tok_a.v && tok_m.v) ? tok_m.t : tok_d.t;
        pkt_tok[2] = tok_d.t;
        pkt_count  = 2'({1'b0, tok_a.v} + {1'b0, tok_m.v} + {1'b0, tok_d.v});
    end

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            acc_reg   <= '0;
            cand_reg  <= 8'hFF;
            held_reg  <= '0;
            halt_reg  <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            cand_reg  <= cand_next;
            held_reg  <= held_next;
            halt_reg  <= halt_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/clx_tokbuf.sv =====
// Result register of the lexer: holds the tokens of one byte and hands them out in order.
// Depends on clx_pkg; loaded from clx_engine.
`default_nettype none

module clx_tokbuf
    import clx_pkg::*;
#(
    parameter int TOK_W = 81
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic [TOK_W-1:0] load_tok [3],
    input  wire logic [1:0]       load_count,
    output logic                  can_load,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  out_last,
    output logic      [TOK_W-1:0] out_tok
);

    logic [TOK_W-1:0] slot_reg [3];
    logic [1:0]       cnt_reg;
    logic [1:0]       idx_reg;
    logic             on_last;

    // The packet frees up when empty or when its last token is taken now.
    assign on_last   = (idx_reg == cnt_reg - 2'd1);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_last  = on_last;
    assign out_tok   = slot_reg[idx_reg];
    assign can_load  = !out_valid || (out_ready && on_last);

    // Count and read index of the packet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (advance)
        begin
            cnt_reg <= load_count;
            idx_reg <= '0;
        end
        else if (can_load)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (out_valid && out_ready)
            idx_reg <= idx_reg + 2'd1;
    end

    // Token slots.
    always_ff @(posedge clk)
    begin
        if (advance)
            slot_reg <= load_tok;
    end

endmodule

`default_nettype wire

// ===== src/c_subset_lexer_unit.sv =====
// Top level of the streaming C-subset lexer: input register, scanner step, result register.
// Depends on clx_pkg, clx_engine and clx_tokbuf.
//
//  channel | direction | tdata                | tuser      | tlast
//  s_*     | in        | text_byte            | -          | end_of_text
//  m_*     | out       | token fields (below) | token_kind | last_of_run
//
// A byte moves from the input register through the scanner into the result register, so
// one byte per cycle is taken while each byte yields at most one token and m_tready is set.
// A byte that yields several tokens (at most 3) holds the result register until its last token is taken.
// Reset returns the scanner to the start of a stream at position zero.
// A stall on m_tready backs up through the result register into the input register.
`default_nettype none

module c_subset_lexer_unit
    import clx_pkg::*;
#(
    parameter int POSITION_BITS = 16,
    parameter int LENGTH_BITS   = 12,
    localparam int TOK_W        = 53 + POSITION_BITS + LENGTH_BITS,
    localparam int DATA_BITS    = TOK_W - 3,
    localparam int TDATA_W      = ((DATA_BITS + 7) / 8) * 8
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,  // text_byte
    input  wire logic               s_tlast,  // end_of_text
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // start_pos, token_length, number_value, keyword_index, punct_first, punct_second
    output logic      [TDATA_W-1:0] m_tdata,
    output logic      [2:0]         m_tuser,  // token_kind
    output logic                    m_tlast   // last_of_run
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_end_reg;
    logic             advance;
    logic             can_load;
    logic [TOK_W-1:0] pkt_tok [3];
    logic [1:0]       pkt_count;
    logic [TOK_W-1:0] out_tok;

    assign advance  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    clx_engine #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .text_byte   (in_byte_reg),
        .end_of_text (in_end_reg),
        .pkt_tok     (pkt_tok),
        .pkt_count   (pkt_count)
    );

    clx_tokbuf #(
        .TOK_W (TOK_W)
    ) u_tokbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .load_tok   (pkt_tok),
        .load_count (pkt_count),
        .can_load   (can_load),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_last   (m_tlast),
        .out_tok    (out_tok)
    );

    // Kind rides in tuser, the remaining fields fill tdata from bit zero.
    assign m_tuser = out_tok[TOK_W-1 -: 3];
    assign m_tdata = TDATA_W'(out_tok[DATA_BITS-1:0]);

endmodule

`default_nettype wire

// ===== src/clx_checker.sv =====
// Port-level checks of the lexer result channel, bound to c_subset_lexer_unit.
// Depends on clx_pkg and c_subset_lexer_unit_macros.svh.
`default_nettype none
`include "c_subset_lexer_unit_macros.svh"

module clx_checker
    import clx_pkg::*;
#(
    parameter int POSITION_BITS = 16,
    parameter int LENGTH_BITS   = 12,
    localparam int TDATA_W      = ((50 + POSITION_BITS + LENGTH_BITS + 7) / 8) * 8,
    localparam int VAL_LO       = POSITION_BITS + LENGTH_BITS
)(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic [7:0]         s_tdata,
    input wire logic               s_tlast,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic [2:0]         m_tuser,
    input wire logic               m_tlast
);

    logic is_eof;
    logic in_req;

    assign is_eof = m_tvalid && (m_tuser == KIND_EOF);
    assign in_req = s_tvalid && s_tready && (s_tdata != 8'h00) && !s_tlast;

    // A stalled request keeps its token.
    `CLX_ASSERT_NEXT(a_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // EOF always closes the run of tokens of its byte.
    `CLX_ASSERT_IMPL(a_eof_last, is_eof, m_tlast)

    // EOF carries zero length and no value.
    `CLX_ASSERT_IMPL(a_eof_empty, is_eof,
        (m_tdata[POSITION_BITS +: LENGTH_BITS] == '0) && (m_tdata[VAL_LO +: 31] == '0))

    // Only number tokens carry a value.
    `CLX_ASSERT_IMPL(a_value_kind, m_tvalid && (m_tuser != KIND_NUMBER),
        m_tdata[VAL_LO +: 31] == '0)

    // Bytes are taken only from a request with a live input handshake.
    `CLX_ASSERT_IMPL(a_in_req, in_req, s_tvalid)

endmodule

bind c_subset_lexer_unit clx_checker #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
) u_clx_checker (.*);

`default_nettype wire
